/* rtl/oid_arc_decoder_defines.svh */
// Assertion macros for the checker file of the arc decoder.
`ifndef OID_ARC_DECODER_DEFINES_SVH
`define OID_ARC_DECODER_DEFINES_SVH

// Plain concurrent assertion, clocked on the rising edge and quiet during reset.
`define OID_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("oid_arc_decoder: assertion failed");

// A condition in one cycle requires the expression to hold its value into the next.
`define OID_ASSERT_HOLD(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(expr)) \
        else $error("oid_arc_decoder: value changed while stalled");

`endif

/* rtl/oid_pkg.sv */
`default_nettype none

package oid_pkg;

    localparam int ARC_WIDTH_DEF = 64;   // default accumulator width
    localparam int ARC_OUT_W     = 64;   // width of the arc field on the result stream
    localparam int OCTET_W       = 8;
    localparam int GROUP_W       = 7;
    localparam int MORE_BIT      = 7;    // continuation flag position in an octet
    localparam int FIRST_DIV     = 40;
    localparam int FIRST_MAX     = 2;
    localparam int RQ_DEPTH      = 4;    // result queue entries

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    typedef enum logic [0:0] {
        REG_IS_RELATIVE = 1'b0
    } t_reg_index;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic                 object_last;
        logic                 run_last;
        t_status              status;
        logic [ARC_OUT_W-1:0] arc_value;
    } t_result;

endpackage

`default_nettype wire

/* rtl/oid_result_fifo.sv */
`default_nettype none

// Small result queue. Takes up to two results per cycle, hands out one.
module oid_result_fifo #(
    parameter int DEPTH = oid_pkg::RQ_DEPTH
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push_a,
    input  wire               i_push_b,
    input  oid_pkg::t_result  i_data_a,
    input  oid_pkg::t_result  i_data_b,
    output logic              o_room_two,
    output logic              o_valid,
    input  wire               i_pop,
    output oid_pkg::t_result  o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    oid_pkg::t_result r_mem [DEPTH];

    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [PTR_W-1:0] wp_b;
    logic             pop_ok;

    assign wp_b       = r_wp + PTR_W'(1);
    assign pop_ok     = i_pop && (r_cnt != '0);
    assign o_valid    = (r_cnt != '0);
    assign o_data     = r_mem[r_rp];
    assign o_room_two = (r_cnt <= CNT_W'(DEPTH - 2));

    always_comb begin
        n_wp  = r_wp + PTR_W'(i_push_a) + PTR_W'(i_push_b);
        n_rp  = r_rp + PTR_W'(pop_ok);
        n_cnt = r_cnt + CNT_W'(i_push_a) + CNT_W'(i_push_b) - CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wp] <= i_data_a;
        end
        if (i_push_b) begin
            r_mem[wp_b] <= i_data_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* rtl/oid_arc_decoder.sv */
// Results are written into the result queue in the cycle in which their octet is accepted.
// Throughput: one octet per cycle while two queue entries are free; the first arc of an absolute identifier gives two
// results, so the result port, one result per cycle, sets the pace for that octet.
// The four-entry result queue takes a new octet whenever two entries are free.
// Reset (i_rst_n, synchronous, active low) clears the arc state, the queue and is_relative.
`default_nettype none

module oid_arc_decoder #(
    parameter int ARC_WIDTH = oid_pkg::ARC_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,

    // Octet stream in.
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [oid_pkg::OCTET_W-1:0]      s_axis_tdata,   // [7:0] octet
    input  wire                              s_axis_tlast,   // end_of_content

    // Arc result stream out.
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [oid_pkg::ARC_OUT_W-1:0]    m_axis_tdata,   // [63:0] arc_value
    output logic [2:0]                       m_axis_tuser,   // [1:0] status, [2] run_last
    output logic                             m_axis_tlast,   // object_last

    // Configuration port.
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [oid_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire  [oid_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [oid_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int W = ARC_WIDTH;

    // Arc state: the groups of the arc in progress, whether no arc of this
    // identifier has been emitted yet, and whether the arc in progress lost bits.
    logic [W-1:0] r_acc, n_acc;
    logic         r_first, n_first;
    logic         r_ovf, n_ovf;
    logic         r_is_relative;

    logic                  accept;
    logic                  more;
    logic                  eoc;
    logic [W-1:0]          acc_sh;
    logic                  ovf_now;
    logic                  ovf_any;
    logic                  ge_lo, ge_hi;
    logic [1:0]            arc0;
    logic [W-1:0]          arc0_scaled;
    logic [W-1:0]          arc1;
    logic                  push_a, push_b;
    oid_pkg::t_result      res_a, res_b, head;
    logic                  room_two;
    logic                  cfg_wr;
    oid_pkg::t_reg_index   reg_idx;

    // ------------------------------------------------------------------
    // Configuration. The register index is the word address; byte-lane
    // bits are ignored. Writes beyond the register list are dropped.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = oid_pkg::t_reg_index'(paddr[oid_pkg::CFG_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            oid_pkg::REG_IS_RELATIVE: prdata = oid_pkg::CFG_DATA_W'(r_is_relative);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_relative <= 1'b0;
        end else if (cfg_wr && (reg_idx == oid_pkg::REG_IS_RELATIVE)) begin
            r_is_relative <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Octet step. The accumulator shifts in seven bits per octet; bits that
    // would fall off the top mark the arc as overflowed instead of wrapping.
    // ------------------------------------------------------------------
    assign s_axis_tready = room_two;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign more          = s_axis_tdata[oid_pkg::MORE_BIT];
    assign eoc           = s_axis_tlast;
    assign acc_sh        = {r_acc[W-oid_pkg::GROUP_W-1:0], s_axis_tdata[oid_pkg::GROUP_W-1:0]};
    assign ovf_now       = (r_acc[W-1 -: oid_pkg::GROUP_W] != '0);
    assign ovf_any       = r_ovf || ovf_now;

    // First arc of an absolute identifier: arc0 = min(v / 40, 2). With the
    // cap at two, two compares against 40 and 80 replace the divide.
    assign ge_hi       = (acc_sh >= W'(oid_pkg::FIRST_DIV * oid_pkg::FIRST_MAX));
    assign ge_lo       = (acc_sh >= W'(oid_pkg::FIRST_DIV));
    assign arc0        = ge_hi ? 2'd2 : (ge_lo ? 2'd1 : 2'd0);
    assign arc0_scaled = ge_hi ? W'(oid_pkg::FIRST_DIV * oid_pkg::FIRST_MAX)
                       : (ge_lo ? W'(oid_pkg::FIRST_DIV) : '0);
    assign arc1        = acc_sh - arc0_scaled;

    always_comb begin
        n_acc   = r_acc;
        n_first = r_first;
        n_ovf   = r_ovf;
        push_a  = 1'b0;
        push_b  = 1'b0;

        res_a.arc_value   = '0;
        res_a.status      = oid_pkg::ST_OK;
        res_a.run_last    = 1'b1;
        res_a.object_last = eoc;
        res_b.arc_value   = oid_pkg::ARC_OUT_W'(arc1);
        res_b.status      = oid_pkg::ST_OK;
        res_b.run_last    = 1'b1;
        res_b.object_last = eoc;

        if (accept) begin
            if (more) begin
                // Continuation octet; at the end of content it means truncation.
                n_acc = acc_sh;
                n_ovf = ovf_any;
                if (eoc) begin
                    push_a       = 1'b1;
                    res_a.status = oid_pkg::ST_TRUNC;
                end
            end else begin
                push_a = 1'b1;
                if (ovf_any) begin
                    res_a.status = oid_pkg::ST_OVERFLOW;
                end else if (!r_is_relative && r_first) begin
                    // Split first arc: arc0 first, then the remainder.
                    res_a.arc_value   = oid_pkg::ARC_OUT_W'(arc0);
                    res_a.run_last    = 1'b0;
                    res_a.object_last = 1'b0;
                    push_b            = 1'b1;
                end else begin
                    res_a.arc_value = oid_pkg::ARC_OUT_W'(acc_sh);
                end
                n_acc   = '0;
                n_ovf   = 1'b0;
                n_first = 1'b0;
            end
            // The end of content always returns the state to its reset value.
            if (eoc) begin
                n_acc   = '0;
                n_ovf   = 1'b0;
                n_first = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_first <= 1'b1;
            r_ovf   <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_first <= n_first;
            r_ovf   <= n_ovf;
        end
    end

    // ------------------------------------------------------------------
    // Result queue. It decouples the octet side from the result side and
    // absorbs the second result of a split first arc.
    // ------------------------------------------------------------------
    oid_result_fifo #(
        .DEPTH (oid_pkg::RQ_DEPTH)
    ) u_result_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_a   (push_a),
        .i_push_b   (push_b),
        .i_data_a   (res_a),
        .i_data_b   (res_b),
        .o_room_two (room_two),
        .o_valid    (m_axis_tvalid),
        .i_pop      (m_axis_tready),
        .o_data     (head)
    );

    assign m_axis_tdata = head.arc_value;
    assign m_axis_tuser = {head.run_last, head.status};
    assign m_axis_tlast = head.object_last;

endmodule

`default_nettype wire

/* rtl/oid_arc_decoder_checker.sv */
`default_nettype none
`include "oid_arc_decoder_defines.svh"

module oid_arc_decoder_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [oid_pkg::ARC_OUT_W-1:0]   m_axis_tdata,
    input wire [2:0]                      m_axis_tuser,
    input wire                            m_axis_tlast
);

    logic err_result;
    logic trunc_result;
    logic ok_result;

    assign err_result   = m_axis_tvalid && (m_axis_tuser[1:0] != oid_pkg::ST_OK);
    assign trunc_result = m_axis_tvalid && (m_axis_tuser[1:0] == oid_pkg::ST_TRUNC);
    assign ok_result    = m_axis_tvalid && (m_axis_tuser[1:0] == oid_pkg::ST_OK);

    // Error results never carry an arc value.
    `OID_ASSERT(a_err_zero_arc, i_clk, i_rst_n, err_result |-> (m_axis_tdata == '0))

    // A truncation can only come from the last octet, so it closes the identifier.
    `OID_ASSERT(a_trunc_ends, i_clk, i_rst_n, trunc_result |-> (m_axis_tlast && m_axis_tuser[2]))

    // The last result of an identifier is always the last result of its octet.
    `OID_ASSERT(a_obj_last_run, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[2])

    // A split first arc: a result that does not end its octet is an ok arc0 of at most two.
    `OID_ASSERT(a_arc0_range, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tuser[2]) |-> (ok_result && (m_axis_tdata <= 64'd2)))

    // A stalled result keeps its value.
    `OID_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tdata)

endmodule

bind oid_arc_decoder oid_arc_decoder_checker u_checker (.*);

`default_nettype wire
